// File: rtl/core/pdmt_pkg.sv
package pdmt_pkg;

  // Width of the prescaler, counter and compare registers.
  localparam int COUNT_WIDTH = 16;
  // Longest run of counted cycles that one tick word may ask for.
  localparam int MAX_TICKS = 255;

  localparam int DATA_WIDTH = 16;
  localparam int TICK_WIDTH = 8;
  localparam int ADDR_WIDTH = 4;
  localparam int INDEX_WIDTH = 3;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [INDEX_WIDTH-1:0] reg_index_t;

  // Request kinds carried in the mode field.
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Register indexes.
  localparam reg_index_t REG_FLAGS     = 3'd0;
  localparam reg_index_t REG_CONTROL   = 3'd1;
  localparam reg_index_t REG_PRESCALER = 3'd2;
  localparam reg_index_t REG_PRESCNT   = 3'd3;
  localparam reg_index_t REG_COUNTER   = 3'd4;
  localparam reg_index_t REG_COMPARE_A = 3'd5;
  localparam reg_index_t REG_COMPARE_B = 3'd6;

  // Control word bit positions.
  localparam int CTRL_ENABLE  = 0;
  localparam int CTRL_FLAG_A  = 1;
  localparam int CTRL_FLAG_B  = 2;
  localparam int CTRL_CLEAR_B = 3;
  localparam int CTRL_CLEAR_A = 4;

  // Flag bit positions.
  localparam int FLAG_A = 0;
  localparam int FLAG_B = 1;

  typedef struct packed {
    mode_t                  mode;
    logic [TICK_WIDTH-1:0]  tick_count;
    logic [ADDR_WIDTH-1:0]  address;
    logic [DATA_WIDTH-1:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic                  irq_line;
  } rsp_t;

endpackage

// File: rtl/core/prescaled_dual_match_timer.sv
// Channel | Direction | Handshake            | Word
// req     | in        | req_valid, req_stall | req_t: mode, tick_count, address, write_data
// rsp     | out       | rsp_valid, rsp_stall | rsp_t: read_data, irq_line
//
// A read, a write, an unused mode, a tick of zero count or a tick while disabled
// goes from idle straight to the done state, which registers its result word.
// An enabled tick passes through the run state before the done state: the single
// prescale/counter/compare step runs once per counted cycle.
// Reset (rst, synchronous) clears every timer register, the flags and the sequencer.
// req_stall is high while a word is in progress; a stalled result is held in the
// output register and the next finished word waits in the done state until it is free.
module prescaled_dual_match_timer
  import pdmt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  logic [1:0]            match_flags, match_flags_next;
  logic [DATA_WIDTH-1:0] control_word;
  count_t                prescale_limit;
  count_t                prescale_count, prescale_count_next;
  count_t                main_count, main_count_next;
  count_t                compare_a;
  count_t                compare_b;
  logic [TICK_WIDTH-1:0] remaining;
  logic [DATA_WIDTH-1:0] read_hold;

  logic                  accept;
  logic                  out_free;
  reg_index_t            index;
  logic [TICK_WIDTH-1:0] ticks;
  logic [DATA_WIDTH-1:0] read_value;
  logic                  wrap;
  logic                  hit_a, hit_b;
  count_t                count_step, count_after_a;
  logic [1:0]            step_flags;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign index     = req.address[ADDR_WIDTH-1:1];

  // Saturate the requested number of cycles.
  always_comb begin
    if (32'(req.tick_count) > MAX_TICKS) begin
      ticks = TICK_WIDTH'(MAX_TICKS);
    end else begin
      ticks = req.tick_count;
    end
  end

  // Register read multiplexer.
  always_comb begin
    unique case (index)
      REG_FLAGS:     read_value = DATA_WIDTH'(match_flags);
      REG_CONTROL:   read_value = control_word;
      REG_PRESCALER: read_value = DATA_WIDTH'(prescale_limit);
      REG_PRESCNT:   read_value = DATA_WIDTH'(prescale_count);
      REG_COUNTER:   read_value = DATA_WIDTH'(main_count);
      REG_COMPARE_A: read_value = DATA_WIDTH'(compare_a);
      REG_COMPARE_B: read_value = DATA_WIDTH'(compare_b);
      default:       read_value = '0;
    endcase
  end

  // One counted cycle: prescaler wrap, counter advance, then match A and match B.
  always_comb begin
    wrap = (prescale_count == prescale_limit);
    if (wrap) begin
      prescale_count_next = '0;
      count_step          = main_count + count_t'(1);
    end else begin
      prescale_count_next = prescale_count + count_t'(1);
      count_step          = main_count;
    end
    hit_a = (count_step == compare_a);
    if (hit_a && control_word[CTRL_CLEAR_A]) begin
      count_after_a = '0;
    end else begin
      count_after_a = count_step;
    end
    hit_b = (count_after_a == compare_b);
    if (hit_b && control_word[CTRL_CLEAR_B]) begin
      main_count_next = '0;
    end else begin
      main_count_next = count_after_a;
    end
    step_flags[FLAG_A] = hit_a && control_word[CTRL_FLAG_A];
    step_flags[FLAG_B] = hit_b && control_word[CTRL_FLAG_B];
    match_flags_next   = match_flags | step_flags;
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.mode == MODE_TICK && control_word[CTRL_ENABLE] && ticks != '0) begin
            state_next = ST_RUN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        if (remaining == TICK_WIDTH'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer and timer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      match_flags    <= '0;
      control_word   <= '0;
      prescale_limit <= '0;
      prescale_count <= '0;
      main_count     <= '0;
      compare_a      <= '0;
      compare_b      <= '0;
      remaining      <= '0;
    end else begin
      state <= state_next;
      if (accept && req.mode == MODE_WRITE) begin
        unique case (index)
          REG_FLAGS:     match_flags    <= '0;
          REG_CONTROL:   control_word   <= req.write_data;
          REG_PRESCALER: prescale_limit <= req.write_data[COUNT_WIDTH-1:0];
          REG_PRESCNT:   prescale_count <= req.write_data[COUNT_WIDTH-1:0];
          REG_COUNTER:   main_count     <= req.write_data[COUNT_WIDTH-1:0];
          REG_COMPARE_A: compare_a      <= req.write_data[COUNT_WIDTH-1:0];
          REG_COMPARE_B: compare_b      <= req.write_data[COUNT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        remaining <= ticks;
      end else if (state == ST_RUN) begin
        remaining      <= remaining - TICK_WIDTH'(1);
        prescale_count <= prescale_count_next;
        main_count     <= main_count_next;
        match_flags    <= match_flags_next;
      end
    end
  end

  // Read data is captured when the word is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (req.mode == MODE_READ) begin
        read_hold <= read_value;
      end else begin
        read_hold <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      rsp.read_data <= read_hold;
      rsp.irq_line  <= |match_flags;
    end
  end

  // A running tick always has cycles left to count.
  assert property (@(posedge clk) disable iff (rst) state == ST_RUN |-> remaining != '0)
    else $error("tick sequencer running with no cycles left");

  // A tick while disabled must not start the counting loop.
  assert property (@(posedge clk) disable iff (rst)
    accept && req.mode == MODE_TICK && !control_word[CTRL_ENABLE] |=> state == ST_DONE)
    else $error("disabled tick entered the counting loop");

  // Flags change only while counting or on an accepted write.
  assert property (@(posedge clk) disable iff (rst)
    state != ST_RUN && !accept |=> $stable(match_flags))
    else $error("match flags changed outside a tick or write");

  // The delivered interrupt level reflects the flags at completion.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_free |=> rsp_valid && rsp.irq_line == |match_flags)
    else $error("result interrupt level disagrees with the flags");

endmodule

// File: sim/prescaled_dual_match_timer_test.sv
`timescale 1ns / 1ps

module prescaled_dual_match_timer_test;
  import pdmt_pkg::*;

  localparam int SCRIPT_LEN   = 25;
  localparam int RANDOM_WORDS = 750;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 1000000;

  // Index 7 has no register behind it.
  localparam reg_index_t REG_UNUSED = 3'd7;

  typedef struct packed {
    req_t word;
    logic fixed;
    rsp_t result;
  } script_row_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  // Timer state as the replies should see it.
  logic [1:0]  model_flags;
  logic [15:0] model_ctrl;
  count_t      model_limit;
  count_t      model_prescnt;
  count_t      model_counter;
  count_t      model_cmp_a;
  count_t      model_cmp_b;

  rsp_t        pending_replies [$];
  rsp_t        oldest;
  int          mismatches      = 0;
  int          replies_checked = 0;
  int          words_sent      = 0;
  int          tick_words      = 0;
  int          read_words      = 0;
  int          write_words     = 0;
  int          hold_left       = 0;
  int          cycles          = 0;
  bit          steady          = 1'b0;

  prescaled_dual_match_timer u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d replies outstanding.",
               cycles, pending_replies.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Apply one word to the timer state and return the reply it should produce.
  function automatic rsp_t timer_response(input req_t w);
    rsp_t        r;
    reg_index_t  idx;
    int unsigned n;
    int unsigned i;
    r   = '0;
    idx = w.address[3:1];
    case (w.mode)
      MODE_TICK: begin
        n = w.tick_count;
        if (n > MAX_TICKS) n = MAX_TICKS;
        if (model_ctrl[CTRL_ENABLE]) begin
          for (i = 0; i < n; i++) begin
            if (model_prescnt == model_limit) begin
              model_prescnt = '0;
              model_counter = model_counter + 1'b1;
            end else begin
              model_prescnt = model_prescnt + 1'b1;
            end
            if (model_counter == model_cmp_a) begin
              if (model_ctrl[CTRL_CLEAR_A]) model_counter = '0;
              if (model_ctrl[CTRL_FLAG_A]) model_flags[FLAG_A] = 1'b1;
            end
            if (model_counter == model_cmp_b) begin
              if (model_ctrl[CTRL_CLEAR_B]) model_counter = '0;
              if (model_ctrl[CTRL_FLAG_B]) model_flags[FLAG_B] = 1'b1;
            end
          end
        end
      end
      MODE_READ: begin
        case (idx)
          REG_FLAGS:     r.read_data = {14'd0, model_flags};
          REG_CONTROL:   r.read_data = model_ctrl;
          REG_PRESCALER: r.read_data = model_limit;
          REG_PRESCNT:   r.read_data = model_prescnt;
          REG_COUNTER:   r.read_data = model_counter;
          REG_COMPARE_A: r.read_data = model_cmp_a;
          REG_COMPARE_B: r.read_data = model_cmp_b;
          default:       r.read_data = '0;
        endcase
      end
      MODE_WRITE: begin
        case (idx)
          REG_FLAGS:     model_flags   = '0;
          REG_CONTROL:   model_ctrl    = w.write_data;
          REG_PRESCALER: model_limit   = w.write_data;
          REG_PRESCNT:   model_prescnt = w.write_data;
          REG_COUNTER:   model_counter = w.write_data;
          REG_COMPARE_A: model_cmp_a   = w.write_data;
          REG_COMPARE_B: model_cmp_b   = w.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
    r.irq_line = |model_flags;
    return r;
  endfunction

  // Directed words. Rows marked fixed carry the reply that can be read off directly.
  function automatic script_row_t script_row(input int k);
    case (k)
      //           mode        ticks   address               data      fixed rd        irq
      // Fresh out of reset, nothing set and nothing running.
      0:  return {MODE_READ,  8'd0,   {REG_FLAGS, 1'b0},     16'h0000, 1'b1, 16'h0000, 1'b0};
      1:  return {MODE_READ,  8'd0,   {REG_UNUSED, 1'b0},    16'h0000, 1'b1, 16'h0000, 1'b0};
      2:  return {MODE_TICK,  8'd255, {REG_FLAGS, 1'b0},     16'h0000, 1'b1, 16'h0000, 1'b0};
      3:  return {MODE_NONE,  8'hff,  {REG_UNUSED, 1'b1},    16'hffff, 1'b1, 16'h0000, 1'b0};
      4:  return {MODE_WRITE, 8'd0,   {REG_UNUSED, 1'b1},    16'hffff, 1'b1, 16'h0000, 1'b0};
      5:  return {MODE_READ,  8'd0,   {REG_CONTROL, 1'b1},   16'h0000, 1'b1, 16'h0000, 1'b0};
      // Both compares with flags, clear on match B, upper control bits stored.
      6:  return {MODE_WRITE, 8'd0,   {REG_PRESCALER, 1'b0}, 16'h0001, 1'b0, 16'h0000, 1'b0};
      7:  return {MODE_WRITE, 8'd0,   {REG_COMPARE_A, 1'b0}, 16'h0003, 1'b0, 16'h0000, 1'b0};
      8:  return {MODE_WRITE, 8'd0,   {REG_COMPARE_B, 1'b0}, 16'h0006, 1'b0, 16'h0000, 1'b0};
      9:  return {MODE_WRITE, 8'd0,   {REG_CONTROL, 1'b0},   16'hffef, 1'b0, 16'h0000, 1'b0};
      10: return {MODE_TICK,  8'd20,  {REG_FLAGS, 1'b0},     16'h0000, 1'b0, 16'h0000, 1'b0};
      11: return {MODE_READ,  8'd0,   {REG_FLAGS, 1'b0},     16'h0000, 1'b0, 16'h0000, 1'b0};
      12: return {MODE_READ,  8'd0,   {REG_COUNTER, 1'b0},   16'h0000, 1'b0, 16'h0000, 1'b0};
      13: return {MODE_READ,  8'd0,   {REG_CONTROL, 1'b0},   16'h0000, 1'b0, 16'h0000, 1'b0};
      14: return {MODE_WRITE, 8'd0,   {REG_FLAGS, 1'b0},     16'hffff, 1'b1, 16'h0000, 1'b0};
      // Prescale count above the limit and a counter about to overflow.
      15: return {MODE_WRITE, 8'd0,   {REG_PRESCALER, 1'b0}, 16'h0002, 1'b0, 16'h0000, 1'b0};
      16: return {MODE_WRITE, 8'd0,   {REG_PRESCNT, 1'b0},   16'hfffe, 1'b0, 16'h0000, 1'b0};
      17: return {MODE_WRITE, 8'd0,   {REG_COUNTER, 1'b1},   16'hffff, 1'b0, 16'h0000, 1'b0};
      18: return {MODE_WRITE, 8'd0,   {REG_CONTROL, 1'b0},   16'h0001, 1'b0, 16'h0000, 1'b0};
      19: return {MODE_TICK,  8'd1,   {REG_FLAGS, 1'b0},     16'h0000, 1'b0, 16'h0000, 1'b0};
      20: return {MODE_READ,  8'd0,   {REG_PRESCNT, 1'b1},   16'h0000, 1'b0, 16'h0000, 1'b0};
      21: return {MODE_TICK,  8'd255, {REG_FLAGS, 1'b0},     16'h0000, 1'b0, 16'h0000, 1'b0};
      22: return {MODE_READ,  8'd0,   {REG_COUNTER, 1'b0},   16'h0000, 1'b0, 16'h0000, 1'b0};
      23: return {MODE_READ,  8'd0,   {REG_COMPARE_B, 1'b1}, 16'h0000, 1'b0, 16'h0000, 1'b0};
      24: return {MODE_TICK,  8'd0,   {REG_FLAGS, 1'b0},     16'h0000, 1'b0, 16'h0000, 1'b0};
      default: return '0;
    endcase
  endfunction

  // A register access with random filler in the fields the block ignores.
  function automatic req_t access(input mode_t m, input reg_index_t idx,
                                  input logic [15:0] data);
    req_t w;
    w.mode       = m;
    w.tick_count = 8'($urandom);
    w.address    = {idx, 1'($urandom)};
    w.write_data = data;
    return w;
  endfunction

  // Mostly small values so that compares actually hit, now and then a wide one.
  function automatic logic [15:0] count_value();
    if ($urandom_range(0, 5) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 24));
  endfunction

  // Offer one word, wait for it to be taken and record the reply it should give.
  task automatic send_word(input req_t w, input logic fixed, input rsp_t fixed_result);
    int   gap;
    rsp_t predicted;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = timer_response(w);
    pending_replies.push_back(fixed ? fixed_result : predicted);
    words_sent++;
    case (w.mode)
      MODE_TICK:  tick_words++;
      MODE_READ:  read_words++;
      MODE_WRITE: write_words++;
      default: ;
    endcase
  endtask

  // Hold off until every outstanding reply has been returned.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Set up a timer configuration, then let it run with reads and changes in between.
  task automatic run_program();
    int          steps;
    int          k;
    logic [15:0] ctrl;
    req_t        w;
    send_word(access(MODE_WRITE, REG_PRESCALER,
                     ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3))),
              1'b0, '0);
    if ($urandom_range(0, 1) == 1)
      send_word(access(MODE_WRITE, REG_PRESCNT,
                       ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'd0), 1'b0, '0);
    if ($urandom_range(0, 1) == 1)
      send_word(access(MODE_WRITE, REG_COUNTER, count_value()), 1'b0, '0);
    send_word(access(MODE_WRITE, REG_COMPARE_A, count_value()), 1'b0, '0);
    send_word(access(MODE_WRITE, REG_COMPARE_B, count_value()), 1'b0, '0);
    ctrl = 16'($urandom);
    ctrl[CTRL_ENABLE] = ($urandom_range(0, 7) != 0);
    send_word(access(MODE_WRITE, REG_CONTROL, ctrl), 1'b0, '0);
    steps = $urandom_range(4, 14);
    for (k = 0; k < steps; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          w = access(MODE_TICK, reg_index_t'($urandom_range(0, 7)), 16'($urandom));
          w.tick_count = ($urandom_range(0, 15) == 0) ? 8'd255 : 8'($urandom_range(0, 40));
        end
        5, 6, 7: w = access(MODE_READ, reg_index_t'($urandom_range(0, 7)), 16'($urandom));
        8:       w = access(MODE_WRITE, REG_FLAGS, 16'($urandom));
        default: w = access(MODE_WRITE, reg_index_t'($urandom_range(0, 7)), count_value());
      endcase
      send_word(w, 1'b0, '0);
    end
  endtask

  // Reply side: take a word, compare it with the oldest expectation, then maybe stall.
  always @(posedge clk) begin
    if (rst) begin
      hold_left = 0;
    end else if (rsp_valid && !rsp_stall) begin
      replies_checked++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected reply word: read_data %h irq_line %b", rsp.read_data,
                   rsp.irq_line);
      end else begin
        oldest = pending_replies.pop_front();
        if (rsp.read_data !== oldest.read_data || rsp.irq_line !== oldest.irq_line) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Reply %0d wrong: read_data %h (expected %h), irq_line %b (expected %b)",
                     replies_checked, rsp.read_data, oldest.read_data, rsp.irq_line,
                     oldest.irq_line);
        end
      end
      hold_left = steady ? 0 : $urandom_range(0, 3);
    end else if (hold_left > 0) begin
      hold_left--;
    end
    rsp_stall <= (hold_left != 0);
  end

  initial begin
    script_row_t row;
    int          k;
    int          burst;
    model_flags   = '0;
    model_ctrl    = '0;
    model_limit   = '0;
    model_prescnt = '0;
    model_counter = '0;
    model_cmp_a   = '0;
    model_cmp_b   = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words first, then let everything settle.
    for (k = 0; k < SCRIPT_LEN; k++) begin
      row = script_row(k);
      send_word(row.word, row.fixed, row.result);
    end
    drain();

    // Random programmes, with the odd burst of arbitrary words in between.
    while (words_sent < SCRIPT_LEN + RANDOM_WORDS) begin
      steady = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6);
        for (k = 0; k < burst; k++)
          send_word({mode_t'(2'($urandom_range(0, 3))), 8'($urandom), 4'($urandom),
                     16'($urandom)}, 1'b0, '0);
      end else begin
        run_program();
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
    steady = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += pending_replies.size();

    $display("Sent %0d words (%0d ticks, %0d reads, %0d writes) over %0d cycles;",
             words_sent, tick_words, read_words, write_words, cycles);
    $display("checked %0d replies against the predicted timer state, %0d mismatches.",
             replies_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: prescaled_dual_match_timer.f
rtl/core/pdmt_pkg.sv
rtl/core/prescaled_dual_match_timer.sv
sim/prescaled_dual_match_timer_test.sv
